// ===== rtl/tsil_pkg.sv =====
// Shared types and constants for the time-series interpolating lookup.
`timescale 1ns / 1ps
`default_nettype none
package tsil_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_ANSWERED = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_STORED   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ORDER    = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] time_ms;
        logic [31:0] distance_cm;
        logic [15:0] power_w;
        logic [7:0]  cadence_rpm;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] distance_out;
        logic [15:0] power_out;
        logic [7:0]  cadence_out;
    } out_beat_t;

    // Datapath commands from the controller.
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_CAPTURE = 4'd1,  // latch input beat
        CMD_CLEAR   = 4'd2,  // count to zero
        CMD_WRITE   = 4'd3,  // store sample at count
        CMD_RD_LAST = 4'd4,  // read entry count-1, open the search range
        CMD_RD_FRST = 4'd5,  // read entry 0
        CMD_RD_MID  = 4'd6,  // read entry mid
        CMD_BISECT  = 4'd7,  // update lo/hi from mid read
        CMD_RD_LO   = 4'd8,
        CMD_RD_HI   = 4'd9,
        CMD_DIV_GO  = 4'd10, // start the divide from the product register
        CMD_DIV_STP = 4'd11,
        CMD_SAVE_A  = 4'd12, // save read data as sample a
        CMD_SAVE_B  = 4'd13, // save read data as sample b
        CMD_RESULT  = 4'd14, // load output register
        CMD_MUL     = 4'd15  // multiply product register
    } cmd_t;

    typedef enum logic [2:0] {
        RES_STATUS = 3'd0,  // status only, zeros
        RES_A      = 3'd1,  // answer sample a
        RES_INTERP = 3'd2   // answer interpolation
    } res_sel_t;

    typedef struct packed {
        cmd_t       cmd;
        res_sel_t   sel;
        logic [2:0] status;
    } ctl_t;

    typedef struct packed {
        logic       is_empty;
        logic       is_full;
        logic       t_below_a;  // query or append time < read sample time
        logic       t_le_a;
        logic       t_ge_a;
        logic       span_one;   // hi - lo <= 1
        logic       div_done;
        logic       zero_span;
        logic [1:0] operation;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/time_series_interpolating_lookup_top.sv =====
// Top level of the time-series interpolating lookup.
// One beat in, one result beat out (operation 3 gives none). A clear, an
// append to an empty or full table and a query of an empty table are answered
// from the decode; any other append first reads the last sample. Other queries
// read the first sample, then the last, and clamp to either; a query between
// samples bisects the table (at most ten probes at 1024 entries) over the
// single registered memory read port, then runs the 64-step one-bit-a-cycle
// divider unless the two samples share a time.
// A new beat is taken in the cycle after the previous result has been accepted.
`timescale 1ns / 1ps
`default_nettype none
module time_series_interpolating_lookup_top
    import tsil_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    ctl_t ctl;
    sts_t sts;

    tsil_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    tsil_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_beat  (s_data),
        .ctl     (ctl),
        .sts     (sts),
        .result  (m_data)
    );

endmodule
`default_nettype wire

// ===== rtl/tsil_datapath.sv =====
// Datapath: sample memory, bisection registers, multiplier and serial divider.
`timescale 1ns / 1ps
`default_nettype none
module tsil_datapath
    import tsil_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_beat_t  s_beat,
    input  wire ctl_t      ctl,
    output sts_t           sts,
    output out_beat_t      result
);

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] d;
        logic [15:0] p;
        logic [7:0]  c;
    } sample_t;

    sample_t            mem [TABLE_DEPTH];
    sample_t            rd_reg;
    in_beat_t           item_reg;
    sample_t            a_reg, b_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  lo_reg, hi_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [32:0]        span_reg;
    logic [5:0]         step_reg;
    logic               neg_reg;
    out_beat_t          res_reg, res_next;
    logic [ADDR_W:0]    mid_sum;
    logic [ADDR_W-1:0]  mid, rd_addr;
    logic [CNT_W-1:0]   last;
    logic [64:0]        trial;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[ADDR_W:1];
    assign last    = count_reg - CNT_W'(1);
    assign trial   = {rem_reg[63:0], quo_reg[63]} - {32'd0, span_reg};

    // Read address selection.
    always_comb begin
        case (ctl.cmd)
            CMD_RD_LAST: rd_addr = last[ADDR_W-1:0];
            CMD_RD_MID:  rd_addr = mid;
            CMD_RD_LO:   rd_addr = lo_reg;
            CMD_RD_HI:   rd_addr = hi_reg;
            default:     rd_addr = '0;
        endcase
    end

    // Sample memory, at most one write and one read per cycle.
    always_ff @(posedge aclk) begin
        if (ctl.cmd == CMD_WRITE) begin
            mem[count_reg[ADDR_W-1:0]] <= {item_reg.time_ms, item_reg.distance_cm,
                                           item_reg.power_w, item_reg.cadence_rpm};
        end
        rd_reg <= mem[rd_addr];
    end

    // Control-side registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.cmd == CMD_CLEAR) begin
            count_reg <= '0;
        end else if (ctl.cmd == CMD_WRITE) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Result beat selected by the controller.
    always_comb begin
        res_next        = '0;
        res_next.status = ctl.status;
        case (ctl.sel)
            RES_A: begin
                res_next.distance_out = a_reg.d;
                res_next.power_out    = a_reg.p;
                res_next.cadence_out  = a_reg.c;
            end
            RES_INTERP: begin
                res_next.distance_out = neg_reg ? a_reg.d - quo_reg[31:0]
                                                : a_reg.d + quo_reg[31:0];
                res_next.power_out    = a_reg.p;
                res_next.cadence_out  = a_reg.c;
            end
            default: ;
        endcase
    end

    // Payload registers and arithmetic.
    always_ff @(posedge aclk) begin
        case (ctl.cmd)
            CMD_CAPTURE: item_reg <= s_beat;
            CMD_RD_LAST: begin
                lo_reg <= '0;
                hi_reg <= last[ADDR_W-1:0];
            end
            CMD_SAVE_A:  a_reg <= rd_reg;
            CMD_SAVE_B:  b_reg <= rd_reg;
            CMD_BISECT: begin
                if (rd_reg.t <= item_reg.time_ms) lo_reg <= mid;
                else hi_reg <= mid;
            end
            CMD_MUL: begin
                neg_reg  <= b_reg.d < a_reg.d;
                span_reg <= {1'b0, b_reg.t - a_reg.t};
                prod_reg <= 64'(item_reg.time_ms - a_reg.t) *
                            64'((b_reg.d < a_reg.d) ? a_reg.d - b_reg.d : b_reg.d - a_reg.d);
            end
            CMD_DIV_GO: begin
                rem_reg  <= '0;
                quo_reg  <= prod_reg;
                step_reg <= '0;
            end
            CMD_DIV_STP: begin
                if (!trial[64]) rem_reg <= trial[63:0];
                else rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg  <= {quo_reg[62:0], ~trial[64]};
                step_reg <= step_reg + 6'd1;
            end
            CMD_RESULT:  res_reg <= res_next;
            default: ;
        endcase
    end

    // Status back to the controller.
    always_comb begin
        sts.is_empty  = (count_reg == '0);
        sts.is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
        sts.t_below_a = item_reg.time_ms < rd_reg.t;
        sts.t_le_a    = item_reg.time_ms <= rd_reg.t;
        sts.t_ge_a    = item_reg.time_ms >= rd_reg.t;
        sts.span_one  = (hi_reg - lo_reg) <= ADDR_W'(1);
        sts.div_done  = step_reg == 6'd63;
        sts.zero_span = b_reg.t <= a_reg.t;
        sts.operation = item_reg.operation;
    end

    assign result = res_reg;

endmodule
`default_nettype wire

// ===== rtl/tsil_ctrl.sv =====
// Controller state machine sequencing append, clear and query beats.
`timescale 1ns / 1ps
`default_nettype none
module tsil_ctrl
    import tsil_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_APCHK  = 14'b00000000000100,
        S_QFRST  = 14'b00000000001000,
        S_QLAST  = 14'b00000000010000,
        S_BMID   = 14'b00000000100000,
        S_BUPD   = 14'b00000001000000,
        S_RDLO   = 14'b00000010000000,
        S_RDHI   = 14'b00000100000000,
        S_SAVEB  = 14'b00001000000000,
        S_MUL    = 14'b00010000000000,
        S_DIVGO  = 14'b00100000000000,
        S_DIV    = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       out_v_reg, out_v_next;
    logic [2:0] stat_reg, stat_next;   // status of the beat in progress
    res_sel_t   sel_reg, sel_next;     // payload source of the beat in progress

    assign s_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            stat_reg  <= ST_ANSWERED;
            sel_reg   <= RES_STATUS;
        end else begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            stat_reg  <= stat_next;
            sel_reg   <= sel_next;
        end
    end

    // Sequencing; read data is registered, so it is used in the state after the read.
    always_comb begin
        state_next = state_reg;
        out_v_next = out_v_reg && !m_ready;
        stat_next  = stat_reg;
        sel_next   = sel_reg;
        ctl        = '{cmd: CMD_NONE, sel: RES_STATUS, status: ST_ANSWERED};
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    ctl.cmd    = CMD_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                sel_next = RES_STATUS;
                case (sts.operation)
                    OP_CLEAR: begin
                        ctl.cmd    = CMD_CLEAR;
                        stat_next  = ST_CLEARED;
                        state_next = S_DONE;
                    end
                    OP_APPEND: begin
                        if (sts.is_full) begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end else if (sts.is_empty) begin
                            ctl.cmd    = CMD_WRITE;
                            stat_next  = ST_STORED;
                            state_next = S_DONE;
                        end else begin
                            ctl.cmd    = CMD_RD_LAST;
                            state_next = S_APCHK;
                        end
                    end
                    OP_QUERY: begin
                        if (sts.is_empty) begin
                            stat_next  = ST_EMPTY;
                            state_next = S_DONE;
                        end else begin
                            ctl.cmd    = CMD_RD_FRST;
                            stat_next  = ST_ANSWERED;
                            state_next = S_QFRST;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_APCHK: begin
                // Last stored sample is in the read register.
                state_next = S_DONE;
                if (sts.t_below_a) begin
                    stat_next = ST_ORDER;
                end else begin
                    ctl.cmd   = CMD_WRITE;
                    stat_next = ST_STORED;
                end
            end
            S_QFRST: begin
                // First sample is in the read register.
                if (sts.t_le_a) begin
                    ctl.cmd    = CMD_SAVE_A;
                    sel_next   = RES_A;
                    state_next = S_DONE;
                end else begin
                    ctl.cmd    = CMD_RD_LAST;
                    state_next = S_QLAST;
                end
            end
            S_QLAST: begin
                // Last sample is in the read register.
                if (sts.t_ge_a) begin
                    ctl.cmd    = CMD_SAVE_A;
                    sel_next   = RES_A;
                    state_next = S_DONE;
                end else begin
                    state_next = S_BMID;
                end
            end
            S_BMID: begin
                if (sts.span_one) begin
                    ctl.cmd    = CMD_RD_LO;
                    state_next = S_RDLO;
                end else begin
                    ctl.cmd    = CMD_RD_MID;
                    state_next = S_BUPD;
                end
            end
            S_BUPD: begin
                ctl.cmd    = CMD_BISECT;
                state_next = S_BMID;
            end
            S_RDLO: begin
                ctl.cmd    = CMD_SAVE_A;
                state_next = S_RDHI;
            end
            S_RDHI: begin
                ctl.cmd    = CMD_RD_HI;
                state_next = S_SAVEB;
            end
            S_SAVEB: begin
                ctl.cmd    = CMD_SAVE_B;
                state_next = S_MUL;
            end
            S_MUL: begin
                ctl.cmd    = CMD_MUL;
                state_next = S_DIVGO;
            end
            S_DIVGO: begin
                ctl.cmd    = CMD_DIV_GO;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (sts.zero_span) begin
                    sel_next   = RES_A;
                    state_next = S_DONE;
                end else begin
                    ctl.cmd = CMD_DIV_STP;
                    if (sts.div_done) begin
                        sel_next   = RES_INTERP;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                ctl        = '{cmd: CMD_RESULT, sel: sel_reg, status: stat_reg};
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tsil_checker.sv =====
// Port-level checker for the lookup top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module tsil_checker
    import tsil_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_beat_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    // A waiting input beat stays valid and unchanged.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while waiting");

    // No new beat is taken while a result waits.
    a_noov: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");

    // Status codes stay within the defined set.
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_CLEARED)
        else $error("bad status code");

    // Non-answer results carry zero distance and power.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_ANSWERED |->
        m_data.distance_out == '0 && m_data.power_out == '0)
        else $error("nonzero payload on status beat");

endmodule

bind time_series_interpolating_lookup_top tsil_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
